>>> src/abb_pkg.sv
// ----------------------------------------------------------------------------
// abb_pkg: shared types and constants of the alpha blend blitter
// Pixel and register field widths, register indexes and the register set.
// ----------------------------------------------------------------------------
package abb_pkg;

  localparam int BYTE_W      = 8;
  localparam int NUM_LANES   = 3;
  localparam int PIXEL_W     = (NUM_LANES + 1) * BYTE_W;
  localparam int SIZE_W      = 13;
  localparam int ORIGIN_W    = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  // Alpha byte written on every blended pixel.
  localparam logic [BYTE_W-1:0] OPAQUE_ALPHA = 8'hFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLEND_ENABLE = 3'd0,
    REG_RECT_WIDTH   = 3'd1,
    REG_RECT_HEIGHT  = 3'd2,
    REG_DST_STRIDE   = 3'd3,
    REG_SRC_STRIDE   = 3'd4,
    REG_DST_ORIGIN   = 3'd5,
    REG_SRC_ORIGIN   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                blend_enable;
    logic [SIZE_W-1:0]   rect_width;
    logic [SIZE_W-1:0]   rect_height;
    logic [SIZE_W-1:0]   dst_stride;
    logic [SIZE_W-1:0]   src_stride;
    logic [ORIGIN_W-1:0] dst_origin;
    logic [ORIGIN_W-1:0] src_origin;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    blend_enable: 1'b0,
    rect_width:   SIZE_W'(1),
    rect_height:  SIZE_W'(1),
    dst_stride:   SIZE_W'(1),
    src_stride:   SIZE_W'(1),
    dst_origin:   '0,
    src_origin:   '0
  };

endpackage

>>> src/abb_if.sv
// ----------------------------------------------------------------------------
// abb_if: valid/ready channels of the alpha blend blitter
// The pixel pair input channel and the result output channel.
// ----------------------------------------------------------------------------
interface abb_in_if;
  import abb_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] src_pixel;
  logic [PIXEL_W-1:0] dst_pixel;

  modport source (output valid, output src_pixel, output dst_pixel, input ready);
  modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface abb_out_if #(
  parameter int ADDR_BITS = 24
);
  import abb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] dst_address;
  logic [ADDR_BITS-1:0] src_address;
  logic [PIXEL_W-1:0]   pixel_out;
  logic                 last;

  modport source (output valid, output dst_address, output src_address,
                  output pixel_out, output last, input ready);
  modport sink   (input valid, input dst_address, input src_address,
                  input pixel_out, input last, output ready);
endinterface

>>> src/alpha_blend_blit.sv
// ----------------------------------------------------------------------------
// alpha_blend_blit: rectangle blit pixel engine with source-over alpha blend
// Every input transaction carries a source and a destination pixel word. The
// engine walks the configured rectangle column by column (x outer, y inner)
// and answers each input transaction with one output transaction: the
// destination and source pixel addresses of the current position (origin +
// x + y * stride, wrapping at 2^ADDR_BITS), the pixel word to write and a
// last flag on the final pixel of the rectangle. With blending on, the three
// color bytes are mixed with the source alpha by three parallel byte lanes
// and the alpha byte is forced opaque; with blending off the source word is
// copied. The engine takes one transaction per clock cycle while its skid
// register is empty; each result is registered in the output register, or in
// the skid register while the output stalls. The combinational path is set
// by the color lanes (two subtracts, one 9 by 9 bit multiply and three adds
// each) and by the two row-offset multipliers of the address walker. The
// output holds two results (output register plus a skid register), so the
// input stays ready while one finished result waits to be taken. The user
// must write registers through the cfg_ port only while the engine is idle;
// the block does not enforce it. A write does not restart the walk, and after
// the final pixel the walk starts over. No start-up pass is needed after
// reset. ADDR_BITS must match the parameter of the output interface instance.
// ----------------------------------------------------------------------------
module alpha_blend_blit #(
  parameter int MAX_DIM   = 4096,
  parameter int ADDR_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [abb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [abb_pkg::CFG_DATA_W-1:0]     cfg_data,
  abb_in_if.sink                             in_ch,
  abb_out_if.source                          out_ch
);
  import abb_pkg::*;

  // --------------------------------------------------------------------------
  // Register file. Writes to an index past the last register are dropped.
  // --------------------------------------------------------------------------
  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_ENABLE: cfg_nxt.blend_enable = cfg_data[0];
        REG_RECT_WIDTH:   cfg_nxt.rect_width   = cfg_data[SIZE_W-1:0];
        REG_RECT_HEIGHT:  cfg_nxt.rect_height  = cfg_data[SIZE_W-1:0];
        REG_DST_STRIDE:   cfg_nxt.dst_stride   = cfg_data[SIZE_W-1:0];
        REG_SRC_STRIDE:   cfg_nxt.src_stride   = cfg_data[SIZE_W-1:0];
        REG_DST_ORIGIN:   cfg_nxt.dst_origin   = cfg_data[ORIGIN_W-1:0];
        REG_SRC_ORIGIN:   cfg_nxt.src_origin   = cfg_data[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The input is refused only when both result slots are full.
  // --------------------------------------------------------------------------
  logic in_ready;
  logic in_fire;
  logic out_free;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;

  assign in_ready = ~skid_valid_r;
  assign in_fire  = in_ch.valid & in_ready;
  assign out_free = ~out_valid_r | out_ch.ready;

  // --------------------------------------------------------------------------
  // Address walker: advances once per accepted transaction.
  // --------------------------------------------------------------------------
  logic [ADDR_BITS-1:0] walk_dst_addr;
  logic [ADDR_BITS-1:0] walk_src_addr;
  logic                 walk_last;

  abb_walker #(
    .MAX_DIM   (MAX_DIM),
    .ADDR_BITS (ADDR_BITS)
  ) u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .step     (in_fire),
    .dst_addr (walk_dst_addr),
    .src_addr (walk_src_addr),
    .last     (walk_last)
  );

  // --------------------------------------------------------------------------
  // Color lanes, one per color byte, all sharing the source alpha.
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0]           src_alpha;
  logic [NUM_LANES*BYTE_W-1:0] lane_bytes;
  logic [PIXEL_W-1:0]          pixel_new;

  assign src_alpha = in_ch.src_pixel[PIXEL_W-1 -: BYTE_W];

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    abb_lane u_lane (
      .src_byte (in_ch.src_pixel[i*BYTE_W +: BYTE_W]),
      .dst_byte (in_ch.dst_pixel[i*BYTE_W +: BYTE_W]),
      .alpha    (src_alpha),
      .mix_byte (lane_bytes[i*BYTE_W +: BYTE_W])
    );
  end

  // Merge: blended bytes with an opaque alpha, or the source word as it is.
  assign pixel_new = cfg_r.blend_enable ? {OPAQUE_ALPHA, lane_bytes} : in_ch.src_pixel;

  // --------------------------------------------------------------------------
  // Output register and skid register. A new result goes to the output
  // register when that slot frees up in this cycle, otherwise to the skid
  // register, which drains into the output register ahead of any new result.
  // --------------------------------------------------------------------------
  logic [ADDR_BITS-1:0] out_dst_r, out_dst_nxt, skid_dst_r, skid_dst_nxt;
  logic [ADDR_BITS-1:0] out_src_r, out_src_nxt, skid_src_r, skid_src_nxt;
  logic [PIXEL_W-1:0]   out_pix_r, out_pix_nxt, skid_pix_r, skid_pix_nxt;
  logic                 out_last_r, out_last_nxt, skid_last_r, skid_last_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_dst_nxt    = out_dst_r;
    out_src_nxt    = out_src_r;
    out_pix_nxt    = out_pix_r;
    out_last_nxt   = out_last_r;
    skid_dst_nxt   = skid_dst_r;
    skid_src_nxt   = skid_src_r;
    skid_pix_nxt   = skid_pix_r;
    skid_last_nxt  = skid_last_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
        out_dst_nxt    = skid_dst_r;
        out_src_nxt    = skid_src_r;
        out_pix_nxt    = skid_pix_r;
        out_last_nxt   = skid_last_r;
      end else if (in_fire) begin
        out_valid_nxt = 1'b1;
        out_dst_nxt   = walk_dst_addr;
        out_src_nxt   = walk_src_addr;
        out_pix_nxt   = pixel_new;
        out_last_nxt  = walk_last;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_dst_nxt   = walk_dst_addr;
      skid_src_nxt   = walk_src_addr;
      skid_pix_nxt   = pixel_new;
      skid_last_nxt  = walk_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dst_r   <= out_dst_nxt;
    out_src_r   <= out_src_nxt;
    out_pix_r   <= out_pix_nxt;
    out_last_r  <= out_last_nxt;
    skid_dst_r  <= skid_dst_nxt;
    skid_src_r  <= skid_src_nxt;
    skid_pix_r  <= skid_pix_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.dst_address = out_dst_r;
  assign out_ch.src_address = out_src_r;
  assign out_ch.pixel_out   = out_pix_r;
  assign out_ch.last        = out_last_r;

endmodule

>>> src/abb_lane.sv
// ----------------------------------------------------------------------------
// abb_lane: one color channel of the source-over blend
// Computes (a*src + (255-a)*dst) / 255, truncated, for one byte.
// ----------------------------------------------------------------------------
module abb_lane (
  input  logic [abb_pkg::BYTE_W-1:0] src_byte,
  input  logic [abb_pkg::BYTE_W-1:0] dst_byte,
  input  logic [abb_pkg::BYTE_W-1:0] alpha,
  output logic [abb_pkg::BYTE_W-1:0] mix_byte
);
  import abb_pkg::*;

  // a*s + (255-a)*d is rewritten as 255*d + a*(s-d): one small signed multiply.
  logic signed [BYTE_W:0]     diff;
  logic signed [2*BYTE_W+1:0] prod;
  logic signed [2*BYTE_W+1:0] sum;
  logic        [2*BYTE_W-1:0] num;
  logic        [2*BYTE_W:0]   quo_acc;

  assign diff = $signed({1'b0, src_byte}) - $signed({1'b0, dst_byte});
  assign prod = $signed({1'b0, alpha}) * diff;
  assign sum  = $signed({2'b00, dst_byte, {BYTE_W{1'b0}}})
              - $signed({{(BYTE_W+2){1'b0}}, dst_byte}) + prod;
  assign num  = sum[2*BYTE_W-1:0];

  // Exact truncating divide by 255 for a 16-bit numerator.
  assign quo_acc  = {1'b0, num} + (2*BYTE_W+1)'(1)
                  + {{(BYTE_W+1){1'b0}}, num[2*BYTE_W-1:BYTE_W]};
  assign mix_byte = quo_acc[2*BYTE_W-1:BYTE_W];

endmodule

>>> src/abb_walker.sv
// ----------------------------------------------------------------------------
// abb_walker: column-major rectangle walker and address generator
// Holds the x and y counters and forms both pixel addresses for each step.
// ----------------------------------------------------------------------------
module abb_walker #(
  parameter int MAX_DIM   = 4096,
  parameter int ADDR_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abb_pkg::cfg_t        cfg,
  input  logic                 step,
  output logic [ADDR_BITS-1:0] dst_addr,
  output logic [ADDR_BITS-1:0] src_addr,
  output logic                 last
);
  import abb_pkg::*;

  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = ((DIM_W > SIZE_W) ? DIM_W : SIZE_W) + 1;
  localparam int PROD_W = CNT_W + SIZE_W;
  localparam int SUM_A  = (ADDR_BITS > PROD_W) ? ADDR_BITS : PROD_W;
  localparam int SUM_W  = (SUM_A > ORIGIN_W) ? SUM_A : ORIGIN_W;
  localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

  // A size of zero acts as one and a size above the limit saturates.
  function automatic logic [CMP_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (v == '0) begin
      return CMP_W'(1);
    end else if (ve > MAX_DIM_C) begin
      return MAX_DIM_C;
    end
    return ve;
  endfunction

  logic [CNT_W-1:0]  col_count_r, col_count_nxt;
  logic [CNT_W-1:0]  row_count_r, row_count_nxt;
  logic [CMP_W-1:0]  eff_w, eff_h;
  logic              col_end, row_end;
  logic [PROD_W-1:0] dst_prod, src_prod;
  logic [SUM_W-1:0]  dst_sum, src_sum;

  assign eff_w = eff_size(cfg.rect_width);
  assign eff_h = eff_size(cfg.rect_height);

  // A counter left beyond a bound shrunk by a register write counts as ended.
  assign col_end = (CMP_W'(col_count_r) + CMP_W'(1)) >= eff_w;
  assign row_end = (CMP_W'(row_count_r) + CMP_W'(1)) >= eff_h;
  assign last    = col_end & row_end;

  assign dst_prod = {{SIZE_W{1'b0}}, row_count_r} * {{CNT_W{1'b0}}, cfg.dst_stride};
  assign src_prod = {{SIZE_W{1'b0}}, row_count_r} * {{CNT_W{1'b0}}, cfg.src_stride};

  assign dst_sum  = SUM_W'(cfg.dst_origin) + SUM_W'(col_count_r) + SUM_W'(dst_prod);
  assign src_sum  = SUM_W'(cfg.src_origin) + SUM_W'(col_count_r) + SUM_W'(src_prod);
  assign dst_addr = dst_sum[ADDR_BITS-1:0];
  assign src_addr = src_sum[ADDR_BITS-1:0];

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (step) begin
      if (row_end) begin
        row_count_nxt = '0;
        col_count_nxt = col_end ? '0 : col_count_r + CNT_W'(1);
      end else begin
        row_count_nxt = row_count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

endmodule

>>> src/abb_checker.sv
// ----------------------------------------------------------------------------
// abb_checker: port-level assertions for the alpha blend blitter
// Tracks outstanding transactions and a few registers from the ports.
// ----------------------------------------------------------------------------
module abb_checker #(
  parameter int ADDR_BITS = 24
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_we,
  input logic [abb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input logic [abb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ADDR_BITS-1:0]             out_dst_address,
  input logic [ADDR_BITS-1:0]             out_src_address,
  input logic [abb_pkg::PIXEL_W-1:0]      out_pixel,
  input logic                             out_last
);
  import abb_pkg::*;

  logic       in_fire, out_fire;
  logic [1:0] pending_r, pending_nxt;
  logic       blend_r, blend_nxt;
  logic       unit_w_r, unit_w_nxt;
  logic       unit_h_r, unit_h_nxt;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_fire && !out_fire) begin
      pending_nxt = pending_r + 2'd1;
    end else if (out_fire && !in_fire) begin
      pending_nxt = pending_r - 2'd1;
    end
    blend_nxt  = blend_r;
    unit_w_nxt = unit_w_r;
    unit_h_nxt = unit_h_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_ENABLE: blend_nxt  = cfg_data[0];
        REG_RECT_WIDTH:   unit_w_nxt = cfg_data[SIZE_W-1:0] <= SIZE_W'(1);
        REG_RECT_HEIGHT:  unit_h_nxt = cfg_data[SIZE_W-1:0] <= SIZE_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      blend_r   <= 1'b0;
      unit_w_r  <= 1'b1;
      unit_h_r  <= 1'b1;
    end else begin
      pending_r <= pending_nxt;
      blend_r   <= blend_nxt;
      unit_w_r  <= unit_w_nxt;
      unit_h_r  <= unit_h_nxt;
    end
  end

  // A stalled result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_last)
      && $stable(out_dst_address) && $stable(out_src_address))
    else $error("stalled output transaction changed");

  // A result is shown exactly when one is owed.
  a_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == (pending_r != 2'd0))
    else $error("output valid disagrees with outstanding count");

  // The input is refused only with both result slots in use.
  a_in_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> pending_r == 2'd2)
    else $error("input refused with a free result slot");

  // Blended pixels are opaque.
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && blend_r |-> out_pixel[PIXEL_W-1 -: BYTE_W] == OPAQUE_ALPHA)
    else $error("blended pixel is not opaque");

  // A one-pixel rectangle ends on every transaction.
  a_unit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && unit_w_r && unit_h_r |-> out_last)
    else $error("one-pixel rectangle result without last");

endmodule

bind alpha_blend_blit abb_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_abb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_we          (cfg_we),
  .cfg_index       (cfg_index),
  .cfg_data        (cfg_data),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_dst_address (out_ch.dst_address),
  .out_src_address (out_ch.src_address),
  .out_pixel       (out_ch.pixel_out),
  .out_last        (out_ch.last)
);

>>> tb/sv/alpha_blend_blit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_blit_checker: result predictor and comparator for the blitter
// Snoops the register port and both channels. For every accepted pixel pair
// it predicts the pixel write from its own register copy and walk counters.
// It then compares each accepted result, in order, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module alpha_blend_blit_checker #(
  parameter int MAX_DIM   = 4096,
  parameter int ADDR_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [abb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [abb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [abb_pkg::PIXEL_W-1:0]     in_src_pixel,
  input  logic [abb_pkg::PIXEL_W-1:0]     in_dst_pixel,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [ADDR_BITS-1:0]            out_dst_address,
  input  logic [ADDR_BITS-1:0]            out_src_address,
  input  logic [abb_pkg::PIXEL_W-1:0]     out_pixel_out,
  input  logic                            out_last,
  output int                              mismatch_count,
  output int                              outstanding
);
  import abb_pkg::*;

  localparam int unsigned ALPHA_MAX = 255;

  typedef struct packed {
    logic [ADDR_BITS-1:0] dst_address;
    logic [ADDR_BITS-1:0] src_address;
    logic [PIXEL_W-1:0]   pixel_out;
    logic                 last;
  } pixel_write_t;

  pixel_write_t expected_writes[$];
  cfg_t         regs;
  int unsigned  col_pos;
  int unsigned  row_pos;

  // A size of zero walks one pixel; sizes above the maximum saturate.
  function automatic int unsigned walk_size(input logic [SIZE_W-1:0] value);
    if (value == '0) return 1;
    if (value > MAX_DIM) return MAX_DIM;
    return value;
  endfunction

  function automatic logic [ADDR_BITS-1:0] pixel_index(input logic [ORIGIN_W-1:0] origin,
                                                       input int unsigned x,
                                                       input int unsigned y,
                                                       input logic [SIZE_W-1:0] stride);
    logic [63:0] sum;
    sum = 64'(origin) + 64'(x) + 64'(y) * 64'(stride);
    return sum[ADDR_BITS-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] mix_lane(input int unsigned src, input int unsigned dst,
                                                 input int unsigned alpha);
    return BYTE_W'((alpha * src + (ALPHA_MAX - alpha) * dst) / ALPHA_MAX);
  endfunction

  function automatic logic [PIXEL_W-1:0] blend_pixel(input logic [PIXEL_W-1:0] src,
                                                     input logic [PIXEL_W-1:0] dst);
    logic [PIXEL_W-1:0] mixed;
    int unsigned        alpha;
    alpha = src[NUM_LANES*BYTE_W +: BYTE_W];
    for (int lane = 0; lane < NUM_LANES; lane++) begin
      mixed[lane*BYTE_W +: BYTE_W] = mix_lane(src[lane*BYTE_W +: BYTE_W],
                                              dst[lane*BYTE_W +: BYTE_W], alpha);
    end
    mixed[NUM_LANES*BYTE_W +: BYTE_W] = OPAQUE_ALPHA;
    return mixed;
  endfunction

  task automatic report_field(input string field, input logic [PIXEL_W-1:0] want,
                              input logic [PIXEL_W-1:0] got);
    $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    pixel_write_t want;
    int unsigned  w;
    int unsigned  h;
    logic         col_end;
    logic         row_end;
    if (!rst_n) begin
      regs           = CFG_RESET;
      col_pos        = 0;
      row_pos        = 0;
      mismatch_count = 0;
      expected_writes.delete();
    end else begin
      if (in_valid && in_ready) begin
        w = walk_size(regs.rect_width);
        h = walk_size(regs.rect_height);
        col_end = (col_pos + 1 >= w);
        row_end = (row_pos + 1 >= h);
        want.dst_address = pixel_index(regs.dst_origin, col_pos, row_pos, regs.dst_stride);
        want.src_address = pixel_index(regs.src_origin, col_pos, row_pos, regs.src_stride);
        want.pixel_out   = regs.blend_enable ? blend_pixel(in_src_pixel, in_dst_pixel)
                                             : in_src_pixel;
        want.last        = col_end && row_end;
        expected_writes.push_back(want);
        if (row_end) begin
          row_pos = 0;
          col_pos = col_end ? 0 : col_pos + 1;
        end else begin
          row_pos = row_pos + 1;
        end
      end

      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h %h %h %b", $time,
                   out_dst_address, out_src_address, out_pixel_out, out_last);
          mismatch_count++;
        end else begin
          want = expected_writes.pop_front();
          if (out_dst_address !== want.dst_address)
            report_field("dst_address", PIXEL_W'(want.dst_address), PIXEL_W'(out_dst_address));
          if (out_src_address !== want.src_address)
            report_field("src_address", PIXEL_W'(want.src_address), PIXEL_W'(out_src_address));
          if (out_pixel_out !== want.pixel_out)
            report_field("pixel_out", want.pixel_out, out_pixel_out);
          if (out_last !== want.last)
            report_field("last", PIXEL_W'(want.last), PIXEL_W'(out_last));
        end
      end

      // Writes to an unused index leave every register alone.
      if (cfg_we) begin
        case (cfg_index)
          REG_BLEND_ENABLE: regs.blend_enable = cfg_data[0];
          REG_RECT_WIDTH:   regs.rect_width   = cfg_data[SIZE_W-1:0];
          REG_RECT_HEIGHT:  regs.rect_height  = cfg_data[SIZE_W-1:0];
          REG_DST_STRIDE:   regs.dst_stride   = cfg_data[SIZE_W-1:0];
          REG_SRC_STRIDE:   regs.src_stride   = cfg_data[SIZE_W-1:0];
          REG_DST_ORIGIN:   regs.dst_origin   = cfg_data[ORIGIN_W-1:0];
          REG_SRC_ORIGIN:   regs.src_origin   = cfg_data[ORIGIN_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = expected_writes.size();
  end

endmodule

>>> tb/sv/alpha_blend_blit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_blit_test: stimulus and verdict for the alpha blend blitter
// Runs a short directed sequence over pixel and register extremes, then a
// long series of random register settings, each followed by a burst of
// random pixel pairs. Both channels stall at random. A checker module
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module alpha_blend_blit_test;
  import abb_pkg::*;

  localparam int MAX_DIM      = 4096;
  localparam int ADDR_BITS    = 24;
  localparam int ITEM_TARGET  = 1800;
  localparam int IDLE_PCT     = 17;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;

  // No register lives at this index; writes to it must be dropped.
  localparam logic [CFG_INDEX_W-1:0] BAD_REG_INDEX = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // While steady is set neither side inserts idle cycles.
  bit steady;
  int items_sent;
  int cycle_count;
  int mismatch_count;
  int outstanding;
  int phase;

  abb_in_if                          in_ch ();
  abb_out_if #(.ADDR_BITS(ADDR_BITS)) out_ch ();

  alpha_blend_blit #(
    .MAX_DIM  (MAX_DIM),
    .ADDR_BITS(ADDR_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  alpha_blend_blit_checker #(
    .MAX_DIM  (MAX_DIM),
    .ADDR_BITS(ADDR_BITS)
  ) blit_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_src_pixel   (in_ch.src_pixel),
    .in_dst_pixel   (in_ch.dst_pixel),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_dst_address(out_ch.dst_address),
    .out_src_address(out_ch.src_address),
    .out_pixel_out  (out_ch.pixel_out),
    .out_last       (out_ch.last),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("alpha_blend_blit_test: done, errors");
      $finish;
    end
  end

  // The result side drops ready on about one cycle in six, except while the
  // test runs a steady stretch. All drives happen on the falling edge so the
  // block sees stable values at the rising edge.
  always @(negedge clk) begin
    out_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Each register write raises the enable for a single cycle; back-to-back
  // writes keep the enable high across cycles.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Offers one pixel pair, possibly after some idle cycles, and returns on
  // the falling edge after the transaction was taken.
  task automatic send_pixel(input logic [PIXEL_W-1:0] src, input logic [PIXEL_W-1:0] dst);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid     = 1'b0;
      in_ch.src_pixel = $urandom;
      in_ch.dst_pixel = $urandom;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.src_pixel = src;
    in_ch.dst_pixel = dst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
    items_sent++;
  endtask

  // Random pixel word with the alpha byte often pinned to either extreme,
  // so that pure copy and pure keep are both common in blend mode.
  function automatic logic [PIXEL_W-1:0] random_pixel();
    logic [PIXEL_W-1:0] word;
    word = $urandom;
    case ($urandom_range(3))
      0: word[NUM_LANES*BYTE_W +: BYTE_W] = '0;
      1: word[NUM_LANES*BYTE_W +: BYTE_W] = '1;
      default: ;
    endcase
    return word;
  endfunction

  // Registers may only change while nothing is in flight.
  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
  endtask

  // Sizes are mostly small so rectangles wrap often; now and then a zero,
  // the maximum, an oversize value or a fully random data word.
  function automatic logic [CFG_DATA_W-1:0] random_size();
    case ($urandom_range(11))
      0:       return '0;
      1:       return CFG_DATA_W'(MAX_DIM);
      2:       return CFG_DATA_W'($urandom_range(8191, MAX_DIM + 1));
      3:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(8, 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_stride();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CFG_DATA_W'(8191);
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(64, 1));
    endcase
  endfunction

  // Origins near the top of the address space force the index to wrap.
  function automatic logic [CFG_DATA_W-1:0] random_origin();
    case ($urandom_range(3))
      0:       return '1 - CFG_DATA_W'($urandom_range(16));
      1:       return '0;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.src_pixel = '0;
    in_ch.dst_pixel = '0;
    out_ch.ready    = 1'b0;
    steady          = 1'b0;
    items_sent      = 0;
    cycle_count     = 0;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: plain copy of a one-pixel rectangle, so every result
    // is marked last and lands at index zero.
    send_pixel('0, '0);
    send_pixel('1, '1);
    wait_drained();

    // A write to the unused index must not disturb anything.
    write_reg(BAD_REG_INDEX, '1);
    send_pixel(32'h80A5_5A01, 32'h7F00_FF00);
    wait_drained();

    // Blend on (upper data bits are don't-care), two columns, and a height
    // of zero that walks as one row.
    write_reg(REG_BLEND_ENABLE, '1);
    write_reg(REG_RECT_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_RECT_HEIGHT, '0);
    send_pixel(32'h00FF_FFFF, 32'h0000_0000);
    send_pixel(32'hFF12_3456, 32'hFFFF_FFFF);
    send_pixel(32'h80FF_00FF, 32'h0000_FF00);
    send_pixel('1, '1);
    wait_drained();

    // Oversize width saturates; zero destination stride keeps every row on
    // the same indices; origins at the top of the space wrap the sums.
    write_reg(REG_RECT_WIDTH, '1);
    write_reg(REG_RECT_HEIGHT, CFG_DATA_W'(3));
    write_reg(REG_DST_STRIDE, '0);
    write_reg(REG_SRC_STRIDE, CFG_DATA_W'(8191));
    write_reg(REG_DST_ORIGIN, '1);
    write_reg(REG_SRC_ORIGIN, 24'hFF_FFFE);
    repeat (5) send_pixel(random_pixel(), random_pixel());
    wait_drained();

    // Shrinking a bound in the middle of the walk: the counters stay put and
    // a counter past the new bound acts as being on the final row or column.
    write_reg(REG_RECT_HEIGHT, CFG_DATA_W'(1));
    repeat (3) send_pixel(random_pixel(), random_pixel());
    wait_drained();
    write_reg(REG_RECT_WIDTH, CFG_DATA_W'(1));
    write_reg(REG_BLEND_ENABLE, 24'hFF_FFFE);
    repeat (2) send_pixel(random_pixel(), random_pixel());

    // Random part: each phase drains, rewrites a random subset of the
    // registers, and pushes a burst of pixel pairs. Bursts rarely line up
    // with the rectangle, so many settings change in the middle of a walk.
    // Every twelfth phase is a long burst with no idle cycles on either side.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      wait_drained();
      steady = (phase % 12 == 5);
      if ($urandom_range(3) != 0) write_reg(REG_BLEND_ENABLE, CFG_DATA_W'($urandom));
      if ($urandom_range(2) != 0) write_reg(REG_RECT_WIDTH, random_size());
      if ($urandom_range(2) != 0) write_reg(REG_RECT_HEIGHT, random_size());
      if ($urandom_range(2) == 0) write_reg(REG_DST_STRIDE, random_stride());
      if ($urandom_range(2) == 0) write_reg(REG_SRC_STRIDE, random_stride());
      if ($urandom_range(2) == 0) write_reg(REG_DST_ORIGIN, random_origin());
      if ($urandom_range(2) == 0) write_reg(REG_SRC_ORIGIN, random_origin());
      if ($urandom_range(15) == 0) write_reg(BAD_REG_INDEX, CFG_DATA_W'($urandom));
      repeat (steady ? 200 : $urandom_range(48, 1))
        send_pixel(random_pixel(), random_pixel());
    end
    steady = 1'b0;

    // Let every result come out, then give the block a few more cycles to
    // show anything it should not produce.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("alpha_blend_blit_test: done, clean");
    end else begin
      $display("alpha_blend_blit_test: done, errors");
    end
    $finish;
  end

endmodule
